[rtl/bd64x_pkg.sv]
package bd64x_pkg;

	// Sextet codes: 0..63 for data, 64 for the pad character.
	typedef logic [6:0] code_t;

	localparam code_t PAD_CODE = 7'd64;

	// Queue between the front and back parts.
	localparam int QDepth = 4;
	localparam int QAW = $clog2(QDepth);
	localparam logic [QAW:0] Q_FULL = (QAW + 1)'(QDepth);

	localparam logic [7:0] KEY_RESET = 8'd5;

	typedef struct packed {
		logic  skip;
		code_t code;
	} map_t;

	// One decoded group waiting for the descrambler.
	typedef struct packed {
		logic            restart;
		logic [2:0]      keep;
		logic [2:0][7:0] bytes;
	} grp_t;

	typedef struct packed {
		logic full;
		logic avail;
	} q_stat_t;

	function automatic map_t map_char(input logic [7:0] ch);
		map_t       m;
		logic [7:0] diff;
		diff   = 8'd0;
		m.skip = 1'b0;
		m.code = 7'd0;
		if (ch >= "A" && ch <= "Z") begin
			diff   = ch - 8'(65);
			m.code = diff[6:0];
		end else if (ch >= "a" && ch <= "z") begin
			diff   = ch - 8'(97) + 8'd26;
			m.code = diff[6:0];
		end else if (ch >= "0" && ch <= "9") begin
			diff   = ch - 8'(48) + 8'd52;
			m.code = diff[6:0];
		end else if (ch == "+") begin
			m.code = 7'd62;
		end else if (ch == "/") begin
			m.code = 7'd63;
		end else if (ch == "=") begin
			m.code = PAD_CODE;
		end else begin
			m.skip = 1'b1;
		end
		return m;
	endfunction

endpackage

[rtl/bd64x_front.sv]
module bd64x_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        char_in,
	input  logic              msg_start,
	output logic              push,
	output bd64x_pkg::grp_t   push_data
);
	import bd64x_pkg::*;

	code_t      hold_q [3];
	logic [1:0] fill_q;
	logic       stopped_q;
	logic       pend_q;

	map_t       m;
	logic [1:0] fill_eff;
	logic       stop_eff;
	logic       take;
	logic       complete;
	code_t      d0, d1, d2, d3;
	logic       pad1, pad2, pad3;
	logic [2:0] present;
	logic [2:0][7:0] b;
	logic [2:0] keep;

	always_comb begin
		m        = map_char(char_in);
		fill_eff = msg_start ? 2'd0 : fill_q;
		stop_eff = msg_start ? 1'b0 : stopped_q;
		take     = accept && !stop_eff && !m.skip;
		complete = take && (fill_eff == 2'd3);

		d0   = hold_q[0];
		d1   = hold_q[1];
		d2   = hold_q[2];
		d3   = m.code;
		pad1 = (d1 == PAD_CODE);
		pad2 = (d2 == PAD_CODE);
		pad3 = (d3 == PAD_CODE);

		// A pad shifts like a code, so a pad in d0 contributes zero bits.
		b[0] = pad1 ? {d0[5:0], 2'b00} : {d0[5:0], d1[5:4]};
		b[1] = pad2 ? {d1[3:0], 4'b0000} : {d1[3:0], d2[5:2]};
		b[2] = pad3 ? {d2[1:0], 6'b000000} : {d2[1:0], d3[5:0]};

		present = {!pad1 && !pad2, !pad1, 1'b1};
		keep[0] = present[0] && (b[0] != 8'd0);
		keep[1] = present[1] && (b[1] != 8'd0);
		keep[2] = present[2] && (b[2] != 8'd0);

		push              = complete && (keep != 3'b000);
		push_data.restart = pend_q;
		push_data.keep    = keep;
		push_data.bytes   = b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= 2'd0;
			stopped_q <= 1'b0;
			pend_q    <= 1'b0;
			hold_q[0] <= 7'd0;
			hold_q[1] <= 7'd0;
			hold_q[2] <= 7'd0;
		end else if (accept) begin
			// A taken code that also starts a message lands in slot zero with the
			// stop flag cleared; the older held codes are overwritten before use.
			if (take) begin
				if (complete) begin
					fill_q    <= 2'd0;
					stopped_q <= pad1 || pad2 || pad3;
				end else begin
					hold_q[fill_eff] <= m.code;
					fill_q           <= fill_eff + 2'd1;
					stopped_q        <= 1'b0;
				end
			end else if (msg_start) begin
				fill_q    <= 2'd0;
				stopped_q <= 1'b0;
				hold_q[0] <= 7'd0;
				hold_q[1] <= 7'd0;
				hold_q[2] <= 7'd0;
			end
			// The index restart travels with the next group that has output.
			if (msg_start) begin
				pend_q <= 1'b1;
			end else if (push) begin
				pend_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/bd64x_queue.sv]
module bd64x_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bd64x_pkg::grp_t   push_data,
	input  logic              pop,
	output bd64x_pkg::grp_t   pop_data,
	output bd64x_pkg::q_stat_t stat
);
	import bd64x_pkg::*;

	grp_t           mem_q [QDepth];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;

	always_comb begin
		pop_data   = mem_q[rd_ptr_q];
		stat.full  = (cnt_q == Q_FULL);
		stat.avail = (cnt_q != '0);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/bd64x_back.sv]
module bd64x_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         key_offset,
	input  bd64x_pkg::grp_t    q_data,
	input  bd64x_pkg::q_stat_t q_stat,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_byte,
	output logic               run_last
);
	import bd64x_pkg::*;

	logic [2:0][7:0] cur_bytes_q;
	logic [2:0]      cur_mask_q;
	logic [7:0]      idx_q;
	logic            out_valid_q;
	logic [7:0]      out_byte_q;
	logic            run_last_q;

	logic            out_ld;
	logic            emit;
	logic [2:0]      sel;
	logic [2:0]      mask_after;
	logic [7:0]      byte_sel;
	logic            cur_free;

	always_comb begin
		out_ld     = !out_valid_q || !out_stall;
		emit       = out_ld && (cur_mask_q != 3'b000);
		sel        = cur_mask_q & (~cur_mask_q + 3'd1);
		mask_after = cur_mask_q & ~sel;
		if (sel[0]) begin
			byte_sel = cur_bytes_q[0];
		end else if (sel[1]) begin
			byte_sel = cur_bytes_q[1];
		end else begin
			byte_sel = cur_bytes_q[2];
		end
		cur_free = (cur_mask_q == 3'b000) || (emit && (mask_after == 3'b000));
		pop      = cur_free && q_stat.avail;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_bytes_q <= q_data.bytes;
		end
		if (emit) begin
			out_byte_q <= byte_sel ^ (idx_q + key_offset);
			run_last_q <= (mask_after == 3'b000);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mask_q  <= 3'b000;
			idx_q       <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_mask_q <= q_data.keep;
			end else if (emit) begin
				cur_mask_q <= mask_after;
			end
			// A new message restarts the index after the last byte of the old one.
			if (pop && q_data.restart) begin
				idx_q <= 8'd0;
			end else if (emit) begin
				idx_q <= idx_q + 8'd1;
			end
			if (out_ld) begin
				out_valid_q <= emit;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;

endmodule

[rtl/base64_decode_xor_descramble_unit.sv]
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   char_in, msg_start
// out       output     out_valid / out_stall out_byte, run_last
// cfg       input      cfg_valid / cfg_ready key_offset
//
// One character is taken every cycle unless in_stall is high; a completed group
// is decoded in the cycle its fourth code arrives and goes into a four-entry group
// queue. Bytes leave one per cycle while out_stall is low, through the queue, the
// current-group register and the output register. Each group yields at most three
// bytes per four characters, so the queue only fills under output stall; in_stall
// is high while it is full. Reset clears all control state and sets key_offset to 5.
module base64_decode_xor_descramble_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_in,
	input  logic       msg_start,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] key_offset
);
	import bd64x_pkg::*;

	logic       cfg_wr;
	logic [7:0] key_q;
	logic       accept;
	logic       push;
	logic       pop;
	grp_t       push_data;
	grp_t       pop_data;
	q_stat_t    q_stat;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign in_stall  = q_stat.full;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= KEY_RESET;
		end else if (cfg_wr) begin
			key_q <= key_offset;
		end
	end

	bd64x_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_in   (char_in),
		.msg_start (msg_start),
		.push      (push),
		.push_data (push_data)
	);

	bd64x_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	bd64x_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_offset (key_q),
		.q_data     (pop_data),
		.q_stat     (q_stat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_last   (run_last)
	);

endmodule

[rtl/bd64x_checker.sv]
module bd64x_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] char_in,
	input logic       msg_start,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       run_last,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic [7:0] key_offset
);

	// A held result keeps its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(run_last))
		else $error("output changed while stalled");

	// The input side can only back up right after it has taken a character.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("in_stall rose without an input transfer");

	// The bytes of one group leave in an unbroken run.
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !run_last |=> out_valid)
		else $error("gap inside a run of bytes");

	// The register port never refuses a write.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind base64_decode_xor_descramble_unit bd64x_checker u_bd64x_checker (.*);
